// ===== sv/pimsr_pkg.sv =====
// Package for the PI motor speed regulator: payload types and control-law constants.
// No dependencies; imported by pi_motor_speed_regulator_top.
package pimsr_pkg;

    // Proportional gain is 48 = 32 + 16, applied as two shifts.
    localparam int unsigned KP_SHIFT_HI = 5;
    localparam int unsigned KP_SHIFT_LO = 4;

    // Proportional error limit (65535 / 48) and integral ceiling (65535 / 2).
    localparam logic [10:0] E_LIMIT   = 11'd1365;
    localparam logic [14:0] SUM_LIMIT = 15'd32767;

    localparam logic [15:0] TARGET_RESET = 16'd1000;
    localparam logic [15:0] SPEED_MAX    = 16'hFFFF;

    typedef logic [15:0] capture_t;
    typedef logic [15:0] speed_t;

    // Result payload, pwm_duty in the low half.
    typedef struct packed {
        logic [15:0] measured_speed;
        logic [15:0] pwm_duty;
    } result_t;

endpackage

// ===== sv/pi_motor_speed_regulator_top.sv =====
// PI motor speed regulator: capture interval, bit-serial speed divider, PI law.
// Depends on pimsr_pkg.
//
//  channel | direction | handshake             | payload (low bit up)
//  --------+-----------+-----------------------+------------------------------------
//  s_      | in        | s_tvalid / s_tready   | s_tdata: capture_count[15:0]
//  m_      | out       | m_tvalid / m_tready   | m_tdata: pwm_duty[15:0],
//          |           |                       |          measured_speed[31:16]
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_data: target_speed[15:0]
//
// Steps: after a capture is accepted, NUM_W restoring-divider steps produce
// one quotient bit of CLOCK_HZ / interval per cycle, then the saturate, law
// and duty steps follow and m_tvalid rises. A zero interval skips the
// divider. s_tready is high only when idle, so a new capture is taken only
// after the duty step of the previous one has finished.
// The result sits in an output register, so the next capture is accepted
// while m_ still stalls; the duty step waits only if that register is full.
// Reset (aresetn low, synchronous) clears previous capture, integral and
// valids, and sets target_speed to 1000. cfg_ready is always high.
module pi_motor_speed_regulator_top #(
    parameter int unsigned CLOCK_HZ      = 8000000,
    parameter int unsigned TIMER_MODULUS = 65535
) (
    input  logic                aclk,
    input  logic                aresetn,
    // capture transactions
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pimsr_pkg::capture_t s_tdata,   // [15:0] capture_count
    // result transactions
    output logic                m_tvalid,
    input  logic                m_tready,
    output pimsr_pkg::result_t  m_tdata,   // [15:0] pwm_duty, [31:16] measured_speed
    // target speed register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data   // [15:0] target_speed
);
    import pimsr_pkg::*;

    // Numerator width and quotient register width (at least 17 so the
    // saturation test always has an upper part to look at).
    localparam int unsigned NUM_W = $clog2(CLOCK_HZ + 1);
    localparam int unsigned QUO_W = (NUM_W > 17) ? NUM_W : 17;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] NUM_VAL  = NUM_W'(CLOCK_HZ);
    localparam logic [15:0]      TMOD     = 16'(TIMER_MODULUS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_LAW,
        ST_DUTY
    } state_t;

    state_t            state_reg;
    logic [15:0]       target_reg;
    capture_t          prev_reg;
    logic [14:0]       integ_reg;
    logic [15:0]       interval_reg;
    logic [NUM_W-1:0]  num_sr_reg;    // numerator bits, MSB shifted out first
    logic [15:0]       rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    speed_t            speed_reg;
    logic [10:0]       e_reg;         // clamped proportional error
    logic              m_tvalid_reg;
    result_t           m_tdata_reg;

    // Interval with timer wrap, 16-bit arithmetic.
    logic [15:0] interval_next;
    always_comb begin
        if (s_tdata > prev_reg) begin
            interval_next = s_tdata - prev_reg;
        end else begin
            interval_next = TMOD - prev_reg + s_tdata;
        end
    end

    // One restoring-division step.
    logic [16:0] trial;
    logic        q_bit;
    logic [16:0] trial_diff;
    always_comb begin
        trial      = {rem_reg, num_sr_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, interval_reg};
        q_bit      = (trial >= {1'b0, interval_reg});
    end

    // PI law on the registered speed.
    logic [15:0] diff_up;     // target - speed
    logic [15:0] diff_dn;     // speed - target
    logic [16:0] integ_sum;
    logic [14:0] integ_next;
    logic [10:0] e_next;
    always_comb begin
        diff_up   = target_reg - speed_reg;
        diff_dn   = speed_reg - target_reg;
        integ_sum = {2'b00, integ_reg} + {1'b0, diff_up};
        if (target_reg > speed_reg) begin
            integ_next = (integ_sum > {2'b00, SUM_LIMIT}) ? SUM_LIMIT : integ_sum[14:0];
            e_next     = (diff_up > {5'd0, E_LIMIT}) ? E_LIMIT : diff_up[10:0];
        end else begin
            integ_next = ({1'b0, integ_reg} > diff_dn)
                       ? 15'({1'b0, integ_reg} - diff_dn) : 15'd0;
            e_next     = 11'd0;
        end
    end

    // duty = 32e + 16e + 2*integral, clamped to 16 bits
    logic [16:0] duty_sum;
    logic [15:0] duty_next;
    always_comb begin
        duty_sum  = (17'(e_reg) << KP_SHIFT_HI) + (17'(e_reg) << KP_SHIFT_LO)
                  + (17'(integ_reg) << 1);
        duty_next = duty_sum[16] ? SPEED_MAX : duty_sum[15:0];
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            target_reg   <= TARGET_RESET;
            prev_reg     <= '0;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            // the duty step reloads the register itself when it drains
            if (m_tvalid_reg && m_tready && state_reg != ST_DUTY) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        prev_reg     <= s_tdata;
                        interval_reg <= interval_next;
                        num_sr_reg   <= NUM_VAL;
                        rem_reg      <= '0;
                        cnt_reg      <= '0;
                        if (interval_next == 16'd0) begin
                            // zero interval saturates the speed
                            quo_reg   <= {QUO_W{1'b1}};
                            state_reg <= ST_SAT;
                        end else begin
                            quo_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg    <= q_bit ? trial_diff[15:0] : trial[15:0];
                    quo_reg    <= {quo_reg[QUO_W-2:0], q_bit};
                    num_sr_reg <= num_sr_reg << 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    speed_reg <= (|quo_reg[QUO_W-1:16]) ? SPEED_MAX : quo_reg[15:0];
                    state_reg <= ST_LAW;
                end
                ST_LAW: begin
                    integ_reg <= integ_next;
                    e_reg     <= e_next;
                    state_reg <= ST_DUTY;
                end
                ST_DUTY: begin
                    if (out_free) begin
                        m_tvalid_reg               <= 1'b1;
                        m_tdata_reg.pwm_duty       <= duty_next;
                        m_tdata_reg.measured_speed <= speed_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef SYNTHESIS
    // an accepted capture goes straight into the divider or the saturate step
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_DIV || state_reg == ST_SAT)
        else $error("capture accept did not start a computation");

    // divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < interval_reg)
        else $error("divider remainder out of range");

    // a new result only appears out of the duty step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DUTY)
        else $error("result valid without a finished computation");

    // a stalled output register holds the duty step
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DUTY && m_tvalid_reg && !m_tready |=> state_reg == ST_DUTY)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== test/testbench.sv =====
// Testbench for pi_motor_speed_regulator_top: capture stream in, duty/speed results out.
// Depends on pimsr_pkg and the regulator RTL; carries its own predictor of the PI law.
`timescale 1ns / 1ps

module testbench;
    import pimsr_pkg::*;

    // Block parameters as instantiated below.
    localparam int unsigned CLK_RATE    = 8000000;
    localparam int unsigned TIMER_WRAP  = 65535;
    // Control law: duty = 48 * e + 2 * integral, e clamped to 1365, integral to 32767.
    localparam int unsigned P_GAIN      = 48;
    localparam int unsigned I_GAIN      = 2;
    localparam int unsigned P_ERR_MAX   = 1365;
    localparam int unsigned INTEG_MAX   = 32767;
    localparam int unsigned DUTY_MAX    = 65535;
    // Watchdog limit on the run length, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned NUM_PHASES  = 8;

    typedef enum int {NO_IDLE, SEND_IDLE, RECV_STALL, BOTH_IDLE} idle_mode_e;

    // ------------------------------------------------------------------
    // Scoreboard: tracks regulator state, queues expected duty/speed pairs
    // in transaction order and compares results as they leave the block.
    // ------------------------------------------------------------------
    class pi_law_tracker;
        logic [15:0] target;
        capture_t    last_capture;
        logic [14:0] integral;
        result_t     want_duty_speed[$];
        int unsigned mismatches;
        int unsigned results_checked;

        function new();
            target          = 16'd1000;
            last_capture    = '0;
            integral        = '0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void set_target(logic [15:0] value);
            target = value;
        endfunction

        function int unsigned pending();
            return want_duty_speed.size();
        endfunction

        // Interval with timer wrap, speed division, then the PI update.
        function result_t predict_duty_speed(capture_t now);
            logic [16:0] wrapped;
            logic [15:0] interval;
            int unsigned speed;
            int unsigned err;
            int unsigned sum;
            int unsigned duty;
            result_t     r;
            if (now > last_capture) begin
                interval = now - last_capture;
            end else begin
                // computed in 16 bits, so a previous capture above the modulus wraps
                wrapped  = 17'(TIMER_WRAP) - {1'b0, last_capture} + {1'b0, now};
                interval = wrapped[15:0];
            end
            if (interval == 16'd0) begin
                speed = 65535;
            end else begin
                speed = CLK_RATE / int'(interval);
                if (speed > 65535) speed = 65535;
            end
            last_capture = now;
            err = 0;
            if (int'(target) > speed) begin
                err = int'(target) - speed;
                sum = int'(integral) + err;
                if (sum > INTEG_MAX) sum = INTEG_MAX;
                integral = sum[14:0];
                if (err > P_ERR_MAX) err = P_ERR_MAX;
            end else begin
                err = speed - int'(target);
                integral = (int'(integral) > err) ? 15'(int'(integral) - err) : 15'd0;
                err = 0;
            end
            duty = P_GAIN * err + I_GAIN * int'(integral);
            if (duty > DUTY_MAX) duty = DUTY_MAX;
            r.pwm_duty       = duty[15:0];
            r.measured_speed = speed[15:0];
            return r;
        endfunction

        function void capture_taken(capture_t now);
            want_duty_speed.push_back(predict_duty_speed(now));
        endfunction

        function void result_seen(result_t got);
            result_t exp_r;
            if (want_duty_speed.size() == 0) begin
                $display("%0t: unexpected result, actual duty %0d speed %0d",
                         $time, got.pwm_duty, got.measured_speed);
                mismatches++;
                return;
            end
            exp_r = want_duty_speed.pop_front();
            results_checked++;
            if (got.pwm_duty !== exp_r.pwm_duty) begin
                $display("%0t: pwm_duty mismatch, expected %0d actual %0d",
                         $time, exp_r.pwm_duty, got.pwm_duty);
                mismatches++;
            end
            if (got.measured_speed !== exp_r.measured_speed) begin
                $display("%0t: measured_speed mismatch, expected %0d actual %0d",
                         $time, exp_r.measured_speed, got.measured_speed);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    capture_t    s_tdata;     // [15:0] capture_count
    logic        m_tvalid;
    logic        m_tready;
    result_t     m_tdata;     // [15:0] pwm_duty, [31:16] measured_speed
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;    // [15:0] target_speed

    pi_motor_speed_regulator_top #(
        .CLOCK_HZ      (CLK_RATE),
        .TIMER_MODULUS (TIMER_WRAP)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pi_law_tracker board = new();

    int unsigned send_idle_pct;   // chance of a gap cycle before each capture
    int unsigned recv_stall_pct;  // chance of m_tready low in a cycle
    int unsigned cycle_count;
    int unsigned captures_sent;
    int unsigned targets_written;
    capture_t    stim_last;       // last capture driven, for building intervals

    // 10 ns clock
    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("pi_motor_speed_regulator_top regression: fail");
            $finish;
        end
    end

    // Result sink: backpressure changes on the falling edge only.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: a transaction completes at the rising edge with both high.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.result_seen(m_tdata);
        end
    end

    function void set_idle(idle_mode_e mode);
        case (mode)
            NO_IDLE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            SEND_IDLE: begin
                send_idle_pct  = 49;
                recv_stall_pct = 0;
            end
            RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 49;
            end
            default: begin
                send_idle_pct  = 24;
                recv_stall_pct = 24;
            end
        endcase
    endfunction

    // Drive one capture; called and returning at a falling edge. tvalid is
    // assigned once per step, so back-to-back transactions keep it high.
    task automatic send_capture(input capture_t value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.capture_taken(value);
        captures_sent++;
        stim_last = value;
        @(negedge aclk);
    endtask

    // Target write, only once every result has drained; every capture makes
    // a result, so an empty queue means the datapath is idle.
    task automatic write_target(input logic [15:0] value);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (board.pending() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_target(value);
        targets_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly edges spaced near the target period, some very short intervals
    // (1 to 122 ticks saturate the speed), some arbitrary timer values.
    task automatic send_random_capture(input logic [15:0] tgt);
        int unsigned period;
        int unsigned iv;
        int unsigned nxt;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            period = (tgt == 0) ? 65535 : CLK_RATE / int'(tgt);
            if (period > 65535) period = 65535;
            iv = period * $urandom_range(50, 150) / 100;
            if (iv < 1) iv = 1;
            if (iv > 65535) iv = 65535;
        end else if (pick < 85) begin
            iv = $urandom_range(0, 200);  // zero gives a repeated capture
        end else begin
            iv = 0;
        end
        if (pick < 85) begin
            nxt = int'(stim_last) + iv;
            while (nxt >= TIMER_WRAP) nxt -= TIMER_WRAP;
        end else begin
            nxt = $urandom_range(0, 65534);
        end
        send_capture(nxt[15:0]);
    endtask

    initial begin
        logic [15:0] phase_target;
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        m_tready        = 1'b0;
        cycle_count     = 0;
        captures_sent   = 0;
        targets_written = 0;
        stim_last       = '0;
        set_idle(NO_IDLE);

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset target of 1000.
        send_capture(16'd0);      // equal to previous: full timer period
        send_capture(16'd8000);   // speed equals target
        send_capture(16'd16000);
        send_capture(16'd16001);  // one-tick interval, speed saturates
        send_capture(16'd16123);  // 122 ticks, quotient above 16 bits
        send_capture(16'd16246);  // 123 ticks, just under saturation
        send_capture(16'd24000);
        send_capture(16'd65534);  // largest capture in timer range
        send_capture(16'd65535);  // previous now at the modulus
        send_capture(16'd0);      // wrapped interval is zero
        send_capture(16'd65535);
        send_capture(16'd65535);  // equal, previous at the modulus
        send_capture(16'd100);    // wrap from the modulus
        send_capture(16'd50);     // ordinary wrap, slow edge
        send_capture(16'd21845);
        send_capture(16'd43690);
        send_capture(16'd43690);  // repeated capture, low speed builds integral
        send_capture(16'd43690);
        send_capture(16'd51690);
        send_capture(16'd59690);

        // Random phases: each writes a new target and uses an idle pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: phase_target = 16'd0;
                1: phase_target = 16'hFFFF;
                2: phase_target = 16'd1;
                3: phase_target = 16'd2500;
                4: phase_target = 16'($urandom_range(0, 65535));
                5: phase_target = 16'd500;
                6: phase_target = 16'($urandom_range(100, 5000));
                default: phase_target = 16'd65534;
            endcase
            write_target(phase_target);
            set_idle(idle_mode_e'(ph % 4));
            repeat (PHASE_ITEMS) send_random_capture(phase_target);
        end

        // Drain, then allow the pipeline latency to show any stray result.
        s_tvalid <= 1'b0;
        set_idle(NO_IDLE);
        while (board.pending() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("ran %0d captures under %0d target settings and four idle patterns",
                 captures_sent, targets_written + 1);
        $display("%0d results checked, %0d mismatches",
                 board.results_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("pi_motor_speed_regulator_top regression: pass");
        end else begin
            $display("pi_motor_speed_regulator_top regression: fail");
        end
        $finish;
    end

endmodule
